// ===== rtl/bths_pkg.sv =====
// ============================================================================
// bths_pkg
// Shared widths, register codes, pipeline types and helper functions for
// the hop channel selection block.
// ============================================================================
package bths_pkg;

  localparam int NUM_CHANNELS = 79;
  localparam int NUM_EVEN     = 40;
  localparam int GRP_W        = 8;
  localparam int NUM_GRP      = 10;

  localparam int CLK_W      = 28;
  localparam int ADDR_W     = 28;
  localparam int CH_W       = 7;
  localparam int FREQ_W     = 12;
  localparam int MAP_LO_W   = 64;
  localparam int MAP_HI_W   = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam int MOD_W            = 28;
  localparam int MOD_BITS_PER_STG = 4;
  localparam int MOD_STAGES       = MOD_W / MOD_BITS_PER_STG;

  // last pipeline valid bit: kernel, three butterfly stages, remainder, select, encode
  localparam int PIPE_LAST = MOD_STAGES + 5;

  localparam logic [FREQ_W-1:0] BASE_FREQ_MHZ = 12'd2402;
  localparam logic [CH_W-1:0]   NUM_CH_DIV    = 7'd79;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AFH_EN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HIGH = 8'd3;

  // butterfly control bit groups, one group per pipeline stage
  localparam logic [13:0] CTRL_MASK_A = 14'h3E00;
  localparam logic [13:0] CTRL_MASK_B = 14'h01F0;
  localparam logic [13:0] CTRL_MASK_C = 14'h000F;

  localparam logic [2:0] STAGE_LO [14] = '{3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd1, 3'd0,
                                           3'd3, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd1};
  localparam logic [2:0] STAGE_HI [14] = '{3'd1, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd2,
                                           3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd2};

  typedef struct packed {
    logic [4:0]  z;
    logic [13:0] ctrl;
    logic [6:0]  e;
    logic [20:0] hi;
  } bf_t;

  typedef struct packed {
    logic [CH_W-1:0]  r;
    logic [MOD_W-1:0] w;
  } md_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch_off;
    logic [NUM_CHANNELS-1:0] hit;
  } sel_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel_index;
    logic [FREQ_W-1:0] frequency_mhz;
    logic              map_empty;
  } out_t;

  // channel held at a position of the bank: evens first, then odds
  function automatic logic [CH_W-1:0] bank_ch(input int i);
    if (i < NUM_EVEN) begin
      return CH_W'(2 * i);
    end
    return CH_W'(2 * (i - NUM_EVEN) + 1);
  endfunction

  // apply the butterfly swaps enabled in ctrl, highest control bit first
  function automatic logic [4:0] bfly_apply(input logic [4:0] z_in, input logic [13:0] ctrl);
    logic [4:0] z;
    logic       bl;
    logic       bh;
    z = z_in;
    for (int s = 13; s >= 0; s--) begin
      if (ctrl[s]) begin
        bl = z[STAGE_LO[s]];
        bh = z[STAGE_HI[s]];
        z[STAGE_LO[s]] = bh;
        z[STAGE_HI[s]] = bl;
      end
    end
    return z;
  endfunction

  // restoring remainder, four dividend bits per call, MSB first
  function automatic md_t mod_step(input md_t cur, input logic [CH_W-1:0] div);
    md_t        nx;
    logic [7:0] t;
    nx = cur;
    for (int b = 0; b < MOD_BITS_PER_STG; b++) begin
      t    = {nx.r, nx.w[MOD_W-1]};
      nx.w = {nx.w[MOD_W-2:0], 1'b0};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      nx.r = t[CH_W-1:0];
    end
    return nx;
  endfunction

endpackage

// ===== rtl/bths_in_if.sv =====
// ============================================================================
// bths_in_if
// Request channel carrying the slot clock value.
// ============================================================================
interface bths_in_if;
  logic                        valid;
  logic                        ready;
  logic [bths_pkg::CLK_W-1:0]  clock_req;

  modport source (output valid, output clock_req, input ready);
  modport sink   (input valid, input clock_req, output ready);
endinterface

// ===== rtl/bths_out_if.sv =====
// ============================================================================
// bths_out_if
// Result channel carrying the selected channel and RF frequency.
// ============================================================================
interface bths_out_if;
  logic                         valid;
  logic                         ready;
  logic [bths_pkg::CH_W-1:0]    channel_index;
  logic [bths_pkg::FREQ_W-1:0]  frequency_mhz;
  logic                         map_empty;

  modport source (output valid, output channel_index, output frequency_mhz,
                  output map_empty, input ready);
  modport sink   (input valid, input channel_index, input frequency_mhz,
                  input map_empty, output ready);
endinterface

// ===== rtl/bths_cfg_if.sv =====
// ============================================================================
// bths_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface bths_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bths_pkg::CFG_IDX_W-1:0]   index;
  logic [bths_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bt_hop_channel_select_top.sv =====
// ============================================================================
// bt_hop_channel_select_top
// One request per cycle sustained while the output spare entry is empty
// (13-stage pipeline, then a two-entry output buffer; a full spare stalls it).
// Reset: synchronous, active low; address 0, adaptive hopping off, all
// channels used. Rank tables follow map writes via group count and offset registers.
// ============================================================================
module bt_hop_channel_select_top (
  input  logic        clk,
  input  logic        rst_n,
  bths_in_if.sink     in_req,
  bths_out_if.source  out_rsp,
  bths_cfg_if.sink    cfg_wr
);

  // configuration registers
  logic [bths_pkg::ADDR_W-1:0]   dev_addr_r;
  logic                          afh_en_r;
  logic [bths_pkg::MAP_LO_W-1:0] map_lo_r;
  logic [bths_pkg::MAP_HI_W-1:0] map_hi_r;

  // map-derived tables
  logic [bths_pkg::NUM_CHANNELS-1:0]  map_all;
  logic [bths_pkg::NUM_CHANNELS-1:0]  bank_used;
  logic [bths_pkg::NUM_GRP*bths_pkg::GRP_W-1:0] bu_pad;
  logic [3:0]                 gcnt_r   [bths_pkg::NUM_GRP];
  logic [3:0]                 gcnt_nxt [bths_pkg::NUM_GRP];
  logic [bths_pkg::CH_W-1:0]  gpre_r   [bths_pkg::NUM_GRP];
  logic [bths_pkg::CH_W-1:0]  gpre_nxt [bths_pkg::NUM_GRP];
  logic [bths_pkg::CH_W-1:0]  rank_r   [bths_pkg::NUM_CHANNELS];
  logic [bths_pkg::CH_W-1:0]  rank_nxt [bths_pkg::NUM_CHANNELS];
  logic [bths_pkg::CH_W-1:0]  used_r;
  logic [bths_pkg::CH_W-1:0]  used_nxt;
  logic [bths_pkg::CH_W-1:0]  div;

  // pipeline
  logic [bths_pkg::PIPE_LAST:0] vld_r;
  logic                 pipe_en;
  bths_pkg::bf_t        p1_r, p1_nxt;
  bths_pkg::bf_t        p2_r, p2_nxt;
  bths_pkg::bf_t        p3_r, p3_nxt;
  bths_pkg::md_t        md_r   [bths_pkg::MOD_STAGES+1];
  bths_pkg::md_t        md_nxt [bths_pkg::MOD_STAGES+1];
  bths_pkg::sel_t       sel_r, sel_nxt;
  bths_pkg::out_t       enc_r, enc_nxt;

  // output buffer
  bths_pkg::out_t       out_d_r, out_d_nxt;
  bths_pkg::out_t       spare_d_r, spare_d_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 spare_v_r, spare_v_nxt;
  logic                 push;
  logic                 pop;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
      afh_en_r   <= 1'b0;
      map_lo_r   <= '1;
      map_hi_r   <= '1;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        bths_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_wr.data[bths_pkg::ADDR_W-1:0];
        bths_pkg::CFG_AFH_EN:   afh_en_r   <= cfg_wr.data[0];
        bths_pkg::CFG_MAP_LOW:  map_lo_r   <= cfg_wr.data[bths_pkg::MAP_LO_W-1:0];
        bths_pkg::CFG_MAP_HIGH: map_hi_r   <= cfg_wr.data[bths_pkg::MAP_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Used-channel ranks in bank order: group counts, group offsets, ranks
  // ---------------------------------------------------------------------------
  assign map_all = {map_hi_r, map_lo_r};

  always_comb begin
    for (int i = 0; i < bths_pkg::NUM_CHANNELS; i++) begin
      bank_used[i] = map_all[bths_pkg::bank_ch(i)];
    end
  end

  assign bu_pad = {{(bths_pkg::NUM_GRP*bths_pkg::GRP_W-bths_pkg::NUM_CHANNELS){1'b0}},
                   bank_used};

  always_comb begin
    logic [bths_pkg::CH_W-1:0] acc;
    for (int g = 0; g < bths_pkg::NUM_GRP; g++) begin
      gcnt_nxt[g] = '0;
      for (int j = 0; j < bths_pkg::GRP_W; j++) begin
        gcnt_nxt[g] = gcnt_nxt[g] + 4'(bu_pad[g*bths_pkg::GRP_W+j]);
      end
    end
    acc = '0;
    for (int g = 0; g < bths_pkg::NUM_GRP; g++) begin
      gpre_nxt[g] = acc;
      acc = acc + {3'b000, gcnt_r[g]};
    end
    used_nxt = acc;
  end

  always_comb begin
    for (int i = 0; i < bths_pkg::NUM_CHANNELS; i++) begin
      rank_nxt[i] = gpre_r[i / bths_pkg::GRP_W];
      for (int j = 0; j < i % bths_pkg::GRP_W; j++) begin
        rank_nxt[i] = rank_nxt[i] +
                      bths_pkg::CH_W'(bu_pad[(i / bths_pkg::GRP_W)*bths_pkg::GRP_W+j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < bths_pkg::NUM_GRP; g++) begin
        gcnt_r[g] <= (g == bths_pkg::NUM_GRP-1) ?
                     4'(bths_pkg::NUM_CHANNELS - g*bths_pkg::GRP_W) : 4'(bths_pkg::GRP_W);
        gpre_r[g] <= bths_pkg::CH_W'(g*bths_pkg::GRP_W);
      end
      for (int i = 0; i < bths_pkg::NUM_CHANNELS; i++) begin
        rank_r[i] <= bths_pkg::CH_W'(i);
      end
      used_r <= bths_pkg::CH_W'(bths_pkg::NUM_CHANNELS);
    end else begin
      gcnt_r <= gcnt_nxt;
      gpre_r <= gpre_nxt;
      rank_r <= rank_nxt;
      used_r <= used_nxt;
    end
  end

  assign div = afh_en_r ? used_r : bths_pkg::NUM_CH_DIV;

  // ---------------------------------------------------------------------------
  // Pipeline: kernel terms, butterfly, remainder, selection, encode
  // ---------------------------------------------------------------------------
  assign pipe_en      = !spare_v_r;
  assign in_req.ready = pipe_en;

  always_comb begin
    logic [bths_pkg::CLK_W-1:0] ck;
    logic [4:0]                 xa;
    logic [4:0]                 c1;
    ck = {in_req.clock_req[bths_pkg::CLK_W-1:2], 2'b00};
    c1 = {dev_addr_r[8], dev_addr_r[6], dev_addr_r[4], dev_addr_r[2], dev_addr_r[0]};
    xa = ck[6:2] + (dev_addr_r[27:23] ^ ck[25:21]);
    p1_nxt.z    = xa ^ {1'b0, dev_addr_r[22:19]};
    p1_nxt.ctrl = {c1 ^ ck[20:16], dev_addr_r[18:10] ^ ck[15:7]};
    p1_nxt.e    = {dev_addr_r[13], dev_addr_r[11], dev_addr_r[9], dev_addr_r[7],
                   dev_addr_r[5], dev_addr_r[3], dev_addr_r[1]};
    p1_nxt.hi   = ck[27:7];
  end

  always_comb begin
    logic [4:0]  perm;
    logic [25:0] v;
    p2_nxt   = p1_r;
    p2_nxt.z = bths_pkg::bfly_apply(p1_r.z, p1_r.ctrl & bths_pkg::CTRL_MASK_A);
    p3_nxt   = p2_r;
    p3_nxt.z = bths_pkg::bfly_apply(p2_r.z, p2_r.ctrl & bths_pkg::CTRL_MASK_B);
    perm     = bths_pkg::bfly_apply(p3_r.z, p3_r.ctrl & bths_pkg::CTRL_MASK_C);
    // fold perm and E into the dividend: one remainder covers the whole sum
    v = {1'b0, p3_r.hi, 4'b0000} + 26'(perm) + 26'(p3_r.e);
    md_nxt[0].r = '0;
    md_nxt[0].w = {2'b00, v};
    for (int j = 1; j <= bths_pkg::MOD_STAGES; j++) begin
      md_nxt[j] = bths_pkg::mod_step(md_r[j-1], div);
    end
  end

  always_comb begin
    logic [bths_pkg::CH_W-1:0] k;
    logic [7:0]                dbl;
    k   = md_r[bths_pkg::MOD_STAGES].r;
    dbl = {k, 1'b0};
    sel_nxt.ch_off = (k < bths_pkg::CH_W'(bths_pkg::NUM_EVEN)) ?
                     dbl[bths_pkg::CH_W-1:0] :
                     bths_pkg::CH_W'(dbl - 8'(bths_pkg::NUM_CHANNELS));
    for (int i = 0; i < bths_pkg::NUM_CHANNELS; i++) begin
      sel_nxt.hit[i] = bank_used[i] && (rank_r[i] == k);
    end
  end

  always_comb begin
    logic [bths_pkg::CH_W-1:0] ch_afh;
    logic [bths_pkg::CH_W-1:0] ch;
    ch_afh = '0;
    for (int i = 0; i < bths_pkg::NUM_CHANNELS; i++) begin
      if (sel_r.hit[i]) begin
        ch_afh = ch_afh | bths_pkg::bank_ch(i);
      end
    end
    // an empty map leaves no hit, so the channel falls to zero
    ch = afh_en_r ? ch_afh : sel_r.ch_off;
    enc_nxt.channel_index = ch;
    enc_nxt.frequency_mhz = bths_pkg::BASE_FREQ_MHZ + bths_pkg::FREQ_W'(ch);
    enc_nxt.map_empty     = afh_en_r && (used_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[bths_pkg::PIPE_LAST-1:0], in_req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      md_r  <= md_nxt;
      sel_r <= sel_nxt;
      enc_r <= enc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with spare entry; hold the pipeline while the spare is full
  // ---------------------------------------------------------------------------
  assign push = pipe_en && vld_r[bths_pkg::PIPE_LAST];
  assign pop  = out_v_r && out_rsp.ready;

  always_comb begin
    out_v_nxt   = out_v_r;
    out_d_nxt   = out_d_r;
    spare_v_nxt = spare_v_r;
    spare_d_nxt = spare_d_r;
    if (out_v_r && !pop) begin
      if (push) begin
        spare_v_nxt = 1'b1;
        spare_d_nxt = enc_r;
      end
    end else if (spare_v_r) begin
      out_v_nxt   = 1'b1;
      out_d_nxt   = spare_d_r;
      spare_v_nxt = 1'b0;
    end else begin
      out_v_nxt = push;
      out_d_nxt = enc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r   <= out_d_nxt;
    spare_d_r <= spare_d_nxt;
  end

  assign out_rsp.valid         = out_v_r;
  assign out_rsp.channel_index = out_d_r.channel_index;
  assign out_rsp.frequency_mhz = out_d_r.frequency_mhz;
  assign out_rsp.map_empty     = out_d_r.map_empty;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_v_r)
    else $error("pushed result did not reach the output register");

  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> out_v_r)
    else $error("spare entry holds a result while the output register is empty");

  a_spare_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(spare_v_r) |-> $past(out_v_r && !out_rsp.ready))
    else $error("spare entry filled without an output stall");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the hop channel selection block. A directed table
// covers reset values, clock extremes, empty and single-channel maps and
// ignored register writes; random phases then sweep address, hopping mode
// and channel map settings over running and random slot clocks. Results
// are checked in order against fixed values or a local hop kernel model.
// ============================================================================
module testbench;
  import bths_pkg::*;

  localparam int PHASES      = 12;
  localparam int PER_PHASE   = 157;
  localparam int LONG_HOLD   = 200;
  localparam int MAP_SETTLE  = 4;
  localparam int END_SETTLE  = 30;

  // register indexes past the end of the list
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_FIRST = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LAST  = 8'hFF;

  localparam logic [CLK_W-1:0]      CLK_MAX  = 28'hFFFFFFF;
  localparam logic [CFG_DATA_W-1:0] DATA_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // butterfly swap pairs, indexed by control bit
  localparam int SWAP_LO [14] = '{0, 2, 1, 3, 0, 1, 0, 3, 1, 0, 2, 1, 0, 1};
  localparam int SWAP_HI [14] = '{1, 3, 2, 4, 4, 3, 2, 4, 4, 3, 4, 3, 3, 2};

  typedef enum logic {ROW_CFG, ROW_HOP} row_kind_e;

  typedef enum int {
    MAP_FULL, MAP_RANDOM, MAP_SINGLE, MAP_SPARSE, MAP_HIGH_ONLY, MAP_LOW_ONLY, MAP_EMPTY
  } map_kind_e;

  typedef enum int {RX_ALWAYS, RX_BUSY_LIGHT, RX_PERIODIC, RX_BUSY_HEAVY} rx_mode_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  fixed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CLK_W-1:0]      clock;
    out_t                  result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  bths_in_if  in_ch();
  bths_out_if out_ch();
  bths_cfg_if cfg_ch();

  bt_hop_channel_select_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch),
    .cfg_wr  (cfg_ch)
  );

  // register image kept in step with accepted writes
  logic [ADDR_W-1:0]   dev_addr_m;
  logic                afh_on_m;
  logic [MAP_LO_W-1:0] map_lo_m;
  logic [MAP_HI_W-1:0] map_hi_m;

  out_t      pending_hops[$];
  stim_row_t dir_rows[$];

  int hops_sent;
  int hops_checked;
  int cfg_writes;
  int unused_writes;
  int stall_cycles;
  int errors;
  int hold_req_cnt;
  int burst_left;
  int steady_left;

  function automatic out_t predict_hop(input logic [CLK_W-1:0] clk_in);
    logic [CLK_W-1:0]          cv;
    logic [4:0]                a_t;
    logic [3:0]                b_t;
    logic [4:0]                c_t;
    logic [8:0]                d_t;
    logic [6:0]                e_t;
    logic [4:0]                z;
    logic [13:0]               ctl;
    logic                      tmp;
    logic [NUM_CHANNELS-1:0]   used_map;
    int unsigned               base_f;
    int unsigned               used;
    int unsigned               k;
    int unsigned               n;
    int unsigned               ch;
    int unsigned               cand;
    logic                      found;
    out_t                      r;
    // the lowest bit pair of clk_in is dropped, so the Y terms vanish
    cv     = {clk_in[CLK_W-1:2], 2'b00};
    a_t    = dev_addr_m[27:23] ^ cv[25:21];
    b_t    = dev_addr_m[22:19];
    c_t    = {dev_addr_m[8], dev_addr_m[6], dev_addr_m[4], dev_addr_m[2], dev_addr_m[0]}
             ^ cv[20:16];
    d_t    = dev_addr_m[18:10] ^ cv[15:7];
    e_t    = {dev_addr_m[13], dev_addr_m[11], dev_addr_m[9], dev_addr_m[7],
              dev_addr_m[5], dev_addr_m[3], dev_addr_m[1]};
    base_f = {cv[27:7], 4'b0000};
    z      = cv[6:2] + a_t;
    z      = z ^ {1'b0, b_t};
    ctl    = {c_t, d_t};
    for (int s = 13; s >= 0; s--) begin
      if (ctl[s]) begin
        tmp            = z[SWAP_LO[s]];
        z[SWAP_LO[s]]  = z[SWAP_HI[s]];
        z[SWAP_HI[s]]  = tmp;
      end
    end
    ch          = 0;
    r.map_empty = 1'b0;
    if (!afh_on_m) begin
      k  = (z + e_t + base_f % NUM_CHANNELS) % NUM_CHANNELS;
      ch = (2 * k) % NUM_CHANNELS;
    end else begin
      used_map = {map_hi_m, map_lo_m};
      used     = $countones(used_map);
      if (used == 0) begin
        r.map_empty = 1'b1;
      end else begin
        k     = (z + e_t + base_f % used) % used;
        n     = 0;
        found = 1'b0;
        // walk the bank (evens, then odds) keeping only used channels
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          cand = (2 * i) % NUM_CHANNELS;
          if (!found && used_map[cand]) begin
            if (n == k) begin
              ch    = cand;
              found = 1'b1;
            end
            n++;
          end
        end
      end
    end
    r.channel_index = CH_W'(ch);
    r.frequency_mhz = BASE_FREQ_MHZ + FREQ_W'(ch);
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEV_ADDR: dev_addr_m = data[ADDR_W-1:0];
      CFG_AFH_EN:   afh_on_m   = data[0];
      CFG_MAP_LOW:  map_lo_m   = data;
      CFG_MAP_HIGH: map_hi_m   = data[MAP_HI_W-1:0];
      default: unused_writes++;
    endcase
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_hop(input logic [CLK_W-1:0] clock);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_HOP;
    r.clock = clock;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_hop_fixed(input logic [CLK_W-1:0] clock,
                                        input logic [CH_W-1:0] ch, input logic emp);
    stim_row_t r;
    r                      = '0;
    r.kind                 = ROW_HOP;
    r.fixed                = 1'b1;
    r.clock                = clock;
    r.result.channel_index = ch;
    r.result.frequency_mhz = BASE_FREQ_MHZ + FREQ_W'(ch);
    r.result.map_empty     = emp;
    dir_rows.push_back(r);
  endfunction

  task automatic send_hop(input logic [CLK_W-1:0] clock, input logic fixed,
                          input out_t result);
    in_ch.valid     <= 1'b1;
    in_ch.clock_req <= clock;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_hops.push_back(fixed ? result : predict_hop(clock));
    hops_sent++;
  endtask

  // burst pacing on the request side
  task automatic pace();
    if (steady_left > 0) begin
      steady_left--;
      return;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic drain_hops();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_hops.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_writes++;
  endtask

  // let the rank tables catch up with the map before new requests
  task automatic cfg_close();
    cfg_ch.valid <= 1'b0;
    repeat (MAP_SETTLE) @(posedge clk);
  endtask

  task automatic pick_setting(input int ph);
    logic [CFG_DATA_W-1:0] addr_d;
    logic [CFG_DATA_W-1:0] en_d;
    logic [CFG_DATA_W-1:0] lo_d;
    logic [CFG_DATA_W-1:0] hi_d;
    map_kind_e             mk;
    int                    pick;
    addr_d = {$urandom, $urandom};
    en_d   = {$urandom, $urandom};
    mk     = map_kind_e'($urandom_range(MAP_FULL, MAP_EMPTY));
    case (ph)
      0: begin
        addr_d = '0;
        en_d   = '0;
        mk     = MAP_RANDOM;
      end
      1: begin
        addr_d = DATA_MAX;
        en_d   = 64'd1;
        mk     = MAP_FULL;
      end
      2: begin
        en_d = 64'd1;
        mk   = MAP_EMPTY;
      end
      3: begin
        en_d = 64'd1;
        mk   = MAP_SINGLE;
      end
      default: ;
    endcase
    lo_d = {$urandom, $urandom};
    hi_d = {$urandom, $urandom};
    case (mk)
      MAP_FULL: begin
        lo_d = DATA_MAX;
        hi_d = DATA_MAX;
      end
      MAP_SINGLE: begin
        pick = $urandom_range(0, NUM_CHANNELS - 1);
        lo_d = '0;
        hi_d = '0;
        if (pick < MAP_LO_W) lo_d[pick] = 1'b1;
        else hi_d[pick - MAP_LO_W] = 1'b1;
      end
      MAP_SPARSE: begin
        lo_d = lo_d & {$urandom, $urandom} & {$urandom, $urandom};
        hi_d = hi_d & {$urandom, $urandom} & {$urandom, $urandom};
      end
      MAP_HIGH_ONLY: lo_d = '0;
      MAP_LOW_ONLY:  hi_d = '0;
      MAP_EMPTY: begin
        lo_d = '0;
        hi_d = '0;
      end
      default: ;
    endcase
    cfg_write(CFG_DEV_ADDR, addr_d);
    cfg_write(CFG_AFH_EN, en_d);
    cfg_write(CFG_MAP_LOW, lo_d);
    cfg_write(CFG_MAP_HIGH, hi_d);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_FIRST, CFG_IDX_UNUSED_LAST)),
                {$urandom, $urandom});
    end
    cfg_close();
  endtask

  // result side: stall pattern of its own, plus long hold-offs on request
  initial begin
    int       hold_left;
    int       hold_ack;
    int       cyc;
    rx_mode_e mode;
    hold_left    = 0;
    hold_ack     = 0;
    cyc          = 0;
    mode         = RX_ALWAYS;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) mode = rx_mode_e'($urandom_range(RX_ALWAYS, RX_BUSY_HEAVY));
      if (hold_left == 0 && hold_req_cnt != hold_ack) begin
        hold_ack++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS:     out_ch.ready <= 1'b1;
          RX_BUSY_LIGHT: out_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC:   out_ch.ready <= (cyc % 5 != 0);
          default:       out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_hops.size() == 0) begin
          $error("result with no request outstanding: channel_index %0d",
                 out_ch.channel_index);
          errors++;
        end else begin
          exp_r = pending_hops.pop_front();
          hops_checked++;
          if (out_ch.channel_index !== exp_r.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   exp_r.channel_index, out_ch.channel_index);
            errors++;
          end
          if (out_ch.frequency_mhz !== exp_r.frequency_mhz) begin
            $error("frequency_mhz: expected %0d, got %0d",
                   exp_r.frequency_mhz, out_ch.frequency_mhz);
            errors++;
          end
          if (out_ch.map_empty !== exp_r.map_empty) begin
            $error("map_empty: expected %0d, got %0d", exp_r.map_empty, out_ch.map_empty);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #800000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t        row;
    logic             in_open;
    logic             cfg_open;
    logic [CLK_W-1:0] slot_clk;
    int               r;
    hops_sent     = 0;
    hops_checked  = 0;
    cfg_writes    = 0;
    unused_writes = 0;
    stall_cycles  = 0;
    errors        = 0;
    burst_left    = 0;
    steady_left   = 0;
    in_open       = 1'b0;
    cfg_open      = 1'b0;
    dev_addr_m    = '0;
    afh_on_m      = 1'b0;
    map_lo_m      = '1;
    map_hi_m      = '1;
    hold_req_cnt    <= 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.clock_req <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: address 0, plain hopping
    row_hop_fixed('0, 7'd0, 1'b0);
    row_hop_fixed(28'h0000003, 7'd0, 1'b0);
    row_hop(CLK_MAX);
    row_hop(28'h0000004);
    // wide write, masked to the address width
    row_cfg(CFG_DEV_ADDR, DATA_MAX);
    row_hop('0);
    row_hop(CLK_MAX);
    row_hop(28'h5555555);
    row_hop(28'hAAAAAAA);
    // adaptive hopping with nothing in the map
    row_cfg(CFG_AFH_EN, 64'd1);
    row_cfg(CFG_MAP_LOW, '0);
    row_cfg(CFG_MAP_HIGH, '0);
    row_hop_fixed('0, 7'd0, 1'b1);
    row_hop_fixed(CLK_MAX, 7'd0, 1'b1);
    row_hop_fixed(28'h1234567, 7'd0, 1'b1);
    // top channel alone, then bottom channel alone
    row_cfg(CFG_MAP_HIGH, 64'h4000);
    row_hop_fixed('0, 7'd78, 1'b0);
    row_hop_fixed(CLK_MAX, 7'd78, 1'b0);
    row_cfg(CFG_MAP_HIGH, '0);
    row_cfg(CFG_MAP_LOW, 64'd1);
    row_hop_fixed(28'h8000000, 7'd0, 1'b0);
    row_hop_fixed(28'h7FFFFFC, 7'd0, 1'b0);
    // enable bit masked off: map ignored; writes past the list dropped
    row_cfg(CFG_AFH_EN, DATA_MAX - 64'd1);
    row_cfg(CFG_IDX_UNUSED_FIRST, DATA_MAX);
    row_cfg(CFG_IDX_UNUSED_LAST, DATA_MAX);
    row_hop('0);
    row_hop(CLK_MAX);
    // full map under adaptive hopping, map high masked
    row_cfg(CFG_MAP_LOW, DATA_MAX);
    row_cfg(CFG_MAP_HIGH, DATA_MAX);
    row_cfg(CFG_AFH_EN, 64'd1);
    row_hop('0);
    row_hop(CLK_MAX);
    row_hop(28'h2AAAAA8);
    row_cfg(CFG_DEV_ADDR, '0);
    row_cfg(CFG_AFH_EN, '0);
    row_hop_fixed('0, 7'd0, 1'b0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (in_open) begin
          drain_hops();
          in_open = 1'b0;
        end
        cfg_write(row.idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_close();
          cfg_open = 1'b0;
        end
        send_hop(row.clock, row.fixed, row.result);
        pace();
        in_open = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_hops();
      pick_setting(ph);
      slot_clk = CLK_W'($urandom);
      for (int i = 0; i < PER_PHASE; i++) begin
        if (ph == 3 && i == 40) begin
          // stop taking results while requests keep coming
          hold_req_cnt <= hold_req_cnt + 1;
          steady_left = 80;
        end
        if (ph == 6 && i == 75) drain_hops();
        r = $urandom_range(0, 9);
        if (r < 6) slot_clk = slot_clk + 28'd4;
        else if (r == 6) slot_clk = slot_clk + CLK_W'($urandom_range(1, 3));
        else slot_clk = CLK_W'($urandom);
        send_hop(slot_clk, 1'b0, '0);
        pace();
      end
    end

    drain_hops();
    repeat (END_SETTLE) @(posedge clk);
    $display("Sent %0d hop requests across %0d register writes (%0d to unused indexes).",
             hops_sent, cfg_writes, unused_writes);
    $display("Checked %0d results; requests held back for %0d cycles by back-pressure.",
             hops_checked, stall_cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bths_pkg.sv
rtl/bths_in_if.sv
rtl/bths_out_if.sv
rtl/bths_cfg_if.sv
rtl/bt_hop_channel_select_top.sv
tb/testbench.sv
